/* rtl/core/fpsa_pkg.sv */
// shared widths, register indexes and beat types of the five point stencil unit
package fpsa_pkg;

  // field widths
  localparam int XW        = 32;
  localparam int CoefW     = 48;
  localparam int CoefHalfW = 24;
  localparam int YW        = 64;
  localparam int CfgW      = 11;
  localparam int CfgIdxW   = 2;
  localparam int RowW      = 11;

  // arithmetic
  localparam int NumTerms   = 5;
  localparam int AccW       = 84;
  localparam int RoundShift = 16;

  // default depth of the row buffers
  localparam int MaxColsDefault = 1024;

  // register reset values
  localparam logic [CfgW-1:0] GridColsReset = 11'd1024;
  localparam logic [CfgW-1:0] GridRowsReset = 11'd1024;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgGridCols = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGridRows = 2'd1;

  // term slots of the multiply pipeline
  localparam int TermCenter = 0;
  localparam int TermEast   = 1;
  localparam int TermWest   = 2;
  localparam int TermNorth  = 3;
  localparam int TermSouth  = 4;

  typedef struct packed {
    logic signed [XW-1:0] x_value;
    logic [CoefW-1:0]     coef_center;
    logic [CoefW-1:0]     coef_east;
    logic [CoefW-1:0]     coef_west;
    logic [CoefW-1:0]     coef_north;
    logic [CoefW-1:0]     coef_south;
  } in_beat_t;

  typedef struct packed {
    logic signed [YW-1:0] y_value;
    logic                 last_of_grid;
    logic                 saturated;
  } out_beat_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] reg_index;
    logic [CfgW-1:0]    wr_data;
  } cfg_beat_t;

  // boundary decisions taken when a beat is accepted
  typedef struct packed {
    logic emit;
    logic north_ok;
    logic south_ok;
    logic west_ok;
    logic east_ok;
    logic last;
  } bound_t;

  // row buffer strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } rb_ctrl_t;

  // neighbor values out of the row buffers
  typedef struct packed {
    logic [XW-1:0] center;
    logic [XW-1:0] east;
    logic [XW-1:0] west;
    logic [XW-1:0] south;
  } nbr_t;

  // operands of one stencil product
  typedef struct packed {
    logic [NumTerms-1:0][XW-1:0]    x;
    logic [NumTerms-1:0][CoefW-1:0] coef;
    logic                           last;
  } mac_op_t;

endpackage

/* rtl/core/fpsa_stream_if.sv */
// valid/ready channel with a typed payload
interface fpsa_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/fpsa_row_buf.sv */
// two row memories with registered reads, write forwarding and a fill count
module fpsa_row_buf #(
  parameter int MaxCols = fpsa_pkg::MaxColsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fpsa_pkg::rb_ctrl_t          ctrl_i,
  input  logic [$clog2(MaxCols)-1:0]  rd_col_i,
  input  logic [fpsa_pkg::XW-1:0]     wr_x_i,
  output fpsa_pkg::nbr_t              nbr_o
);

  localparam int AW = $clog2(MaxCols);
  localparam int FW = $clog2(MaxCols + 1);

  logic [fpsa_pkg::XW-1:0] prev_mem  [MaxCols];
  logic [fpsa_pkg::XW-1:0] older_mem [MaxCols];

  logic [fpsa_pkg::XW-1:0] prev_c_q, prev_e_q, older_c_q;
  logic [fpsa_pkg::XW-1:0] byp_x_q, byp_old_q, last_center_q;
  logic [AW-1:0]           col_q, east_addr;
  logic [FW-1:0]           fill_q, fill_d;
  logic                    hit_c_q, hit_e_q, vld_c_q, vld_e_q;
  logic [fpsa_pkg::XW-1:0] center;

  // east neighbor address, kept inside the array
  assign east_addr = (rd_col_i == AW'(MaxCols - 1)) ? '0 : rd_col_i + 1'b1;

  // memories: write back the beat in flight, read the next one
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      prev_mem[col_q]  <= wr_x_i;
      older_mem[col_q] <= center;
    end
    if (ctrl_i.rd_en) begin
      prev_c_q  <= prev_mem[rd_col_i];
      prev_e_q  <= prev_mem[east_addr];
      older_c_q <= older_mem[rd_col_i];
    end
  end

  // payload kept with the read: column and forwarded data; the last center is kept on the write
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      col_q     <= rd_col_i;
      byp_x_q   <= wr_x_i;
      byp_old_q <= center;
    end
    if (ctrl_i.wr_en) begin
      last_center_q <= center;
    end
  end

  // written columns always form a prefix from column zero
  always_comb begin
    fill_d = fill_q;
    if (ctrl_i.wr_en && (FW'(col_q) == fill_q)) begin
      fill_d = fill_q + 1'b1;
    end
  end

  // hit and valid flags of the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      hit_c_q <= 1'b0;
      hit_e_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_e_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (ctrl_i.rd_en) begin
        hit_c_q <= ctrl_i.wr_en && (col_q == rd_col_i);
        hit_e_q <= ctrl_i.wr_en && (col_q == east_addr);
        vld_c_q <= FW'(rd_col_i) < fill_q;
        vld_e_q <= FW'(east_addr) < fill_q;
      end
    end
  end

  // corrected neighbor values, unwritten entries read as zero
  always_comb begin
    center = hit_c_q ? byp_x_q : (vld_c_q ? prev_c_q : '0);
    nbr_o.center = center;
    nbr_o.east   = hit_e_q ? byp_x_q : (vld_e_q ? prev_e_q : '0);
    nbr_o.south  = hit_c_q ? byp_old_q : (vld_c_q ? older_c_q : '0);
    nbr_o.west   = last_center_q;
  end

endmodule

/* rtl/core/fpsa_mac.sv */
// four stage multiply, sum, round and saturate pipeline
module fpsa_mac (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  fpsa_pkg::mac_op_t    op_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fpsa_pkg::out_beat_t  out_o
);

  localparam int XW   = fpsa_pkg::XW;
  localparam int HW   = fpsa_pkg::CoefHalfW;
  localparam int PW   = XW + 1 + HW + 1;
  localparam int AccW = fpsa_pkg::AccW;
  localparam int NT   = fpsa_pkg::NumTerms;
  localparam int YW   = fpsa_pkg::YW;
  localparam int RS   = fpsa_pkg::RoundShift;

  logic va_q, vb_q, vc_q, vd_q;
  logic la_q, lb_q, lc_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  logic signed [PW-1:0]   plo_d [NT];
  logic signed [PW-1:0]   phi_d [NT];
  logic signed [PW-1:0]   plo_q [NT];
  logic signed [PW-1:0]   phi_q [NT];
  logic signed [AccW-1:0] term_d [NT];
  logic signed [AccW-1:0] term_q [NT];
  logic signed [AccW-1:0] s01_q, s23_q, s4r_q, sum;
  fpsa_pkg::out_beat_t    res_d, res_q;

  // stall chain, bubbles collapse
  assign rdy_d      = !vd_q || out_ready_i;
  assign rdy_c      = !vc_q || rdy_d;
  assign rdy_b      = !vb_q || rdy_c;
  assign rdy_a      = !va_q || rdy_b;
  assign in_ready_o = rdy_a;

  // partial products, center added and the rest subtracted
  always_comb begin
    logic signed [XW:0]   xe;
    logic signed [XW:0]   xs;
    logic signed [HW:0]   clo;
    logic signed [HW:0]   chi;
    for (int k = 0; k < NT; k++) begin
      xe  = $signed({op_i.x[k][XW-1], op_i.x[k]});
      xs  = (k == fpsa_pkg::TermCenter) ? xe : -xe;
      clo = $signed({1'b0, op_i.coef[k][HW-1:0]});
      chi = $signed({1'b0, op_i.coef[k][2*HW-1:HW]});
      plo_d[k] = xs * clo;
      phi_d[k] = xs * chi;
    end
  end

  // each term recombined from its halves
  always_comb begin
    for (int k = 0; k < NT; k++) begin
      term_d[k] = $signed({{(AccW-PW){plo_q[k][PW-1]}}, plo_q[k]})
                + $signed({{(AccW-PW-HW){phi_q[k][PW-1]}}, phi_q[k], {HW{1'b0}}});
    end
  end

  // final sum, clip to the signed output range
  always_comb begin
    logic [AccW-YW-RS:0] top;
    sum = s01_q + s23_q + s4r_q;
    top = sum[AccW-1:YW+RS-1];
    res_d.last_of_grid = lc_q;
    if ((top == '0) || (top == '1)) begin
      res_d.y_value   = sum[YW+RS-1:RS];
      res_d.saturated = 1'b0;
    end else begin
      res_d.saturated = 1'b1;
      res_d.y_value   = sum[AccW-1] ? {1'b1, {(YW-1){1'b0}}} : {1'b0, {(YW-1){1'b1}}};
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= in_valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
      if (rdy_d) vd_q <= vc_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy_a) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
      la_q  <= op_i.last;
    end
    if (va_q && rdy_b) begin
      term_q <= term_d;
      lb_q   <= la_q;
    end
    if (vb_q && rdy_c) begin
      s01_q <= term_q[fpsa_pkg::TermCenter] + term_q[fpsa_pkg::TermEast];
      s23_q <= term_q[fpsa_pkg::TermWest] + term_q[fpsa_pkg::TermNorth];
      s4r_q <= term_q[fpsa_pkg::TermSouth] + $signed(AccW'(1) <<< (RS - 1));
      lc_q  <= lb_q;
    end
    if (vc_q && rdy_d) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = vd_q;
  assign out_o       = res_q;

endmodule

/* rtl/core/five_point_stencil_apply_unit.sv */
// top level of the five point stencil matrix-vector product unit
//
//   channel       dir  beat contents
//   in_stream_i   in   x_value, coef_center/east/west/north/south
//   out_stream_o  out  y_value, last_of_grid, saturated
//   cfg_i         in   reg_index, wr_data (grid_cols, grid_rows)
//
// one input beat per cycle unless the output stalls; the row buffers read
// three words a cycle from two memories and the write of the previous beat is
// forwarded into the next read; a result leaves from the output register
// reset clears counters and fill count; no clearing pass over the row memories
// a stalled output fills pipeline bubbles first, then holds the input channel
module five_point_stencil_apply_unit #(
  parameter int MaxCols = fpsa_pkg::MaxColsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  fpsa_stream_if.sink   in_stream_i,
  fpsa_stream_if.source out_stream_o,
  fpsa_stream_if.sink   cfg_i
);

  localparam int AW   = $clog2(MaxCols);
  localparam int FW   = $clog2(MaxCols + 1);
  localparam int CfgW = fpsa_pkg::CfgW;
  localparam int LW   = (FW > CfgW) ? FW : CfgW;
  localparam int RowW = fpsa_pkg::RowW;

  logic [CfgW-1:0]  grid_cols_q, grid_rows_q;
  logic [AW-1:0]    col_q, col_d;
  logic [RowW-1:0]  row_q, row_d, rows_w;
  logic [LW-1:0]    cols_w;
  logic             last_col;
  logic             in_fire, s1_fire, s1_ready, s1_valid_q;
  logic             mac_ready;
  fpsa_pkg::bound_t   bound, s1_bound_q;
  fpsa_pkg::in_beat_t s1_beat_q;
  fpsa_pkg::rb_ctrl_t rb_ctrl;
  fpsa_pkg::nbr_t     nbr;
  fpsa_pkg::mac_op_t  mac_op;

  // configuration writes, always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= fpsa_pkg::GridColsReset;
      grid_rows_q <= fpsa_pkg::GridRowsReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.reg_index)
        fpsa_pkg::CfgGridCols: grid_cols_q <= cfg_i.data.wr_data;
        fpsa_pkg::CfgGridRows: grid_rows_q <= cfg_i.data.wr_data;
        default: ;
      endcase
    end
  end

  // effective grid size
  always_comb begin
    if (grid_cols_q == '0) begin
      cols_w = LW'(1);
    end else if (LW'(grid_cols_q) > LW'(MaxCols)) begin
      cols_w = LW'(MaxCols);
    end else begin
      cols_w = LW'(grid_cols_q);
    end
    rows_w = (grid_rows_q == '0) ? RowW'(1) : grid_rows_q;
  end

  assign last_col = (LW'(col_q) + LW'(1)) >= cols_w;

  // boundary flags of the cell one row behind
  always_comb begin
    bound.emit     = row_q != '0;
    bound.north_ok = row_q < rows_w;
    bound.south_ok = row_q >= RowW'(2);
    bound.west_ok  = col_q != '0;
    bound.east_ok  = !last_col;
    bound.last     = last_col && (row_q >= rows_w);
  end

  // raster position counters
  always_comb begin
    col_d = col_q + 1'b1;
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = (row_q >= rows_w) ? '0 : row_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // read stage handshake: a row zero beat only writes back
  assign s1_ready          = !s1_valid_q || mac_ready || !s1_bound_q.emit;
  assign s1_fire           = s1_valid_q && s1_ready;
  assign in_stream_i.ready = s1_ready;
  assign in_fire           = in_stream_i.valid && s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_bound_q <= '0;
    end else if (s1_ready) begin
      s1_valid_q <= in_stream_i.valid;
      if (in_stream_i.valid) begin
        s1_bound_q <= bound;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_beat_q <= in_stream_i.data;
    end
  end

  // row buffers
  assign rb_ctrl.rd_en = in_fire;
  assign rb_ctrl.wr_en = s1_fire;

  fpsa_row_buf #(
    .MaxCols (MaxCols)
  ) u_row_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (rb_ctrl),
    .rd_col_i (col_q),
    .wr_x_i   (s1_beat_q.x_value),
    .nbr_o    (nbr)
  );

  // operands with out-of-grid neighbors zeroed
  always_comb begin
    mac_op.x[fpsa_pkg::TermCenter]    = nbr.center;
    mac_op.x[fpsa_pkg::TermEast]      = s1_bound_q.east_ok ? nbr.east : '0;
    mac_op.x[fpsa_pkg::TermWest]      = s1_bound_q.west_ok ? nbr.west : '0;
    mac_op.x[fpsa_pkg::TermNorth]     = s1_bound_q.north_ok ? s1_beat_q.x_value : '0;
    mac_op.x[fpsa_pkg::TermSouth]     = s1_bound_q.south_ok ? nbr.south : '0;
    mac_op.coef[fpsa_pkg::TermCenter] = s1_beat_q.coef_center;
    mac_op.coef[fpsa_pkg::TermEast]   = s1_beat_q.coef_east;
    mac_op.coef[fpsa_pkg::TermWest]   = s1_beat_q.coef_west;
    mac_op.coef[fpsa_pkg::TermNorth]  = s1_beat_q.coef_north;
    mac_op.coef[fpsa_pkg::TermSouth]  = s1_beat_q.coef_south;
    mac_op.last                       = s1_bound_q.last;
  end

  fpsa_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q && s1_bound_q.emit),
    .in_ready_o  (mac_ready),
    .op_i        (mac_op),
    .out_valid_o (out_stream_o.valid),
    .out_ready_i (out_stream_o.ready),
    .out_o       (out_stream_o.data)
  );

  // a new read never lands on a read stage beat that is not leaving
  a_read_stage_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s1_valid_q) |-> s1_fire)
    else $error("beat accepted over a held read stage beat");

  // columns advance by one inside a line
  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !last_col) |=> (col_q == AW'($past(col_q) + 1'b1)))
    else $error("column counter skipped");

  // the last cell of the grid wraps both counters
  a_grid_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_col && (row_q >= rows_w)) |=> ((row_q == '0) && (col_q == '0)))
    else $error("grid end did not wrap the counters");

endmodule
